// ===== rtl/avr_opcode_coverage_profiler_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the opcode coverage profiler
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef AVR_OPCODE_COVERAGE_PROFILER_UNIT_MACROS_SVH
`define AVR_OPCODE_COVERAGE_PROFILER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled at the rising edge, off during reset.
`define OCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("profiler assertion failed");

// Next-cycle implication, sampled at the rising edge, off during reset.
`define OCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("profiler assertion failed");

`else

`define OCP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OCP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/ocp_pkg.sv =====
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared types, constants and decode tables of the opcode coverage profiler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ocp_pkg;

  localparam int NumClasses = 28;
  localparam int ClassW     = 5;
  localparam int CountW     = 16;
  localparam int MaxWordsDefault = 32768;

  localparam logic [ClassW-1:0] ClassOther = 5'd27;

  // Priority pattern list: the first matching entry gives the class.
  localparam int NumPatterns = 28;

  localparam logic [15:0] PatMask [NumPatterns] = '{
    16'hffff, 16'hff00, 16'hfc00, 16'hfc00, 16'hfc00, 16'hfc00, 16'hfc00,
    16'hfc00, 16'hfc00, 16'hfc00, 16'hfc00, 16'hfc00, 16'hfc00, 16'hf000,
    16'hf000, 16'hf000, 16'hf000, 16'hf000, 16'hfe0f, 16'hfe0f, 16'hf000,
    16'hf000, 16'hfe0f, 16'hfe0e, 16'hfc00, 16'hfc00, 16'hf000, 16'hfe0e
  };

  localparam logic [15:0] PatMatch [NumPatterns] = '{
    16'h0000, 16'h0100, 16'h0400, 16'h0800, 16'h0c00, 16'h1000, 16'h1400,
    16'h1800, 16'h1c00, 16'h2000, 16'h2400, 16'h2800, 16'h2c00, 16'h3000,
    16'h4000, 16'h5000, 16'h6000, 16'h7000, 16'h9200, 16'h9000, 16'h8000,
    16'ha000, 16'h940c, 16'h940e, 16'hc000, 16'hd000, 16'hf000, 16'h9400
  };

  localparam logic [ClassW-1:0] PatClass [NumPatterns] = '{
    5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,
    5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13,
    5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20,
    5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26
  };

  typedef struct packed {
    logic [ClassW-1:0] word_class;
    logic              simple;
    logic              native;
    logic              two_word;
  } dec_t;

  typedef struct packed {
    logic [ClassW-1:0] word_class;
    logic              consumed;
    logic              simple_flag;
    logic              native_flag;
    logic              blocker_flag;
    logic [CountW-1:0] class_tally;
    logic [CountW-1:0] words_total;
    logic [CountW-1:0] simple_total;
    logic [CountW-1:0] native_total;
    logic [CountW-1:0] native_runs;
    logic [CountW-1:0] native_run_words;
    logic [CountW-1:0] longest_run;
  } res_t;

  function automatic logic [ClassW-1:0] classify(input logic [15:0] w);
    logic [ClassW-1:0] cls;
    cls = ClassOther;
    // Walk from the lowest priority up so the first match in the list wins.
    for (int i = NumPatterns - 1; i >= 0; i--) begin
      if ((w & PatMask[i]) == PatMatch[i]) cls = PatClass[i];
    end
    return cls;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v,
                                                input logic [CountW-1:0] cap);
    return (v < cap) ? v + 16'd1 : cap;
  endfunction

endpackage

// ===== rtl/ocp_decode.sv =====
// ----------------------------------------------------------------------------
// ocp_decode
// Combinational opcode decoder: class, simple/native flags, two-word detect.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ocp_decode (
  input  logic [15:0]   word,
  output ocp_pkg::dec_t dec
);

  logic [15:0] hi6;
  logic [15:0] hi4;
  logic [15:0] hi8;
  logic [15:0] tw;
  logic        base;

  assign hi6  = word & 16'hfc00;
  assign hi4  = word & 16'hf000;
  assign hi8  = word & 16'hff00;
  assign tw   = word & 16'hfe0f;
  assign base = (word == 16'h0000) || (hi8 == 16'h0100);

  always_comb begin
    dec.word_class = ocp_pkg::classify(word);
    dec.simple = base ||
                 hi6 == 16'h0400 || hi6 == 16'h0800 || hi6 == 16'h0c00 ||
                 hi6 == 16'h1400 || hi6 == 16'h1800 || hi6 == 16'h1c00 ||
                 hi4 == 16'h2000 || hi4 == 16'h3000 || hi4 == 16'h4000 ||
                 hi4 == 16'h5000 || hi4 == 16'h6000 || hi4 == 16'h7000 ||
                 hi4 == 16'he000;
    dec.native = base || hi4 == 16'he000 ||
                 hi6 == 16'h2c00 || hi6 == 16'h2000 || hi6 == 16'h2400 ||
                 hi6 == 16'h2800 || hi4 == 16'h6000 || hi4 == 16'h7000;
    dec.two_word = tw == 16'h9200 || tw == 16'h9000 ||
                   tw == 16'h940c || tw == 16'h940e;
  end

endmodule

// ===== rtl/ocp_tally.sv =====
// ----------------------------------------------------------------------------
// ocp_tally
// Running totals, per-class blocker counts and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ocp_tally #(
  parameter int MAX_WORDS = ocp_pkg::MaxWordsDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          present,
  input  ocp_pkg::dec_t dec,
  output ocp_pkg::res_t res
);

  localparam logic [ocp_pkg::CountW-1:0] Cap =
    (MAX_WORDS < 65535) ? ocp_pkg::CountW'(MAX_WORDS) : 16'hffff;

  logic                          skip_r,    skip_nxt;
  logic [ocp_pkg::CountW-1:0]    run_r,     run_nxt;
  logic [ocp_pkg::CountW-1:0]    words_r,   words_nxt;
  logic [ocp_pkg::CountW-1:0]    simple_r,  simple_nxt;
  logic [ocp_pkg::CountW-1:0]    native_r,  native_nxt;
  logic [ocp_pkg::CountW-1:0]    runs_r,    runs_nxt;
  logic [ocp_pkg::CountW-1:0]    rwords_r,  rwords_nxt;
  logic [ocp_pkg::CountW-1:0]    longest_r, longest_nxt;
  logic [ocp_pkg::CountW-1:0]    blk_r [ocp_pkg::NumClasses];
  logic [ocp_pkg::CountW-1:0]    blk_cur;
  logic [ocp_pkg::CountW-1:0]    blk_inc;
  logic [ocp_pkg::CountW-1:0]    run_inc;
  logic                          blk_wr;
  ocp_pkg::res_t                 res_r, res_nxt;

  assign blk_cur = blk_r[dec.word_class];
  assign blk_inc = ocp_pkg::sat_inc(blk_cur, Cap);
  assign run_inc = ocp_pkg::sat_inc(run_r, Cap);

  always_comb begin
    skip_nxt    = skip_r;
    run_nxt     = run_r;
    words_nxt   = words_r;
    simple_nxt  = simple_r;
    native_nxt  = native_r;
    runs_nxt    = runs_r;
    rwords_nxt  = rwords_r;
    longest_nxt = longest_r;
    blk_wr      = 1'b0;
    res_nxt     = '0;
    if (skip_r) begin
      skip_nxt = 1'b0;
    end else if (!present) begin
      run_nxt = '0;
    end else begin
      res_nxt.word_class   = dec.word_class;
      res_nxt.consumed     = 1'b1;
      res_nxt.simple_flag  = dec.simple;
      res_nxt.native_flag  = dec.native;
      res_nxt.blocker_flag = !dec.native;
      words_nxt = ocp_pkg::sat_inc(words_r, Cap);
      if (dec.simple) simple_nxt = ocp_pkg::sat_inc(simple_r, Cap);
      if (dec.native) begin
        native_nxt = ocp_pkg::sat_inc(native_r, Cap);
        if (run_r == '0) runs_nxt = ocp_pkg::sat_inc(runs_r, Cap);
        run_nxt    = run_inc;
        rwords_nxt = ocp_pkg::sat_inc(rwords_r, Cap);
        if (run_inc > longest_r) longest_nxt = run_inc;
        res_nxt.class_tally = blk_cur;
      end else begin
        run_nxt  = '0;
        blk_wr   = 1'b1;
        skip_nxt = dec.two_word;
        res_nxt.class_tally = blk_inc;
      end
    end
    res_nxt.words_total      = words_nxt;
    res_nxt.simple_total     = simple_nxt;
    res_nxt.native_total     = native_nxt;
    res_nxt.native_runs      = runs_nxt;
    res_nxt.native_run_words = rwords_nxt;
    res_nxt.longest_run      = longest_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r    <= 1'b0;
      run_r     <= '0;
      words_r   <= '0;
      simple_r  <= '0;
      native_r  <= '0;
      runs_r    <= '0;
      rwords_r  <= '0;
      longest_r <= '0;
      for (int i = 0; i < ocp_pkg::NumClasses; i++) blk_r[i] <= '0;
    end else if (step) begin
      skip_r    <= skip_nxt;
      run_r     <= run_nxt;
      words_r   <= words_nxt;
      simple_r  <= simple_nxt;
      native_r  <= native_nxt;
      runs_r    <= runs_nxt;
      rwords_r  <= rwords_nxt;
      longest_r <= longest_nxt;
      if (blk_wr) blk_r[dec.word_class] <= blk_inc;
    end
  end

  // Result payload needs no reset; its valid bit lives in the top level.
  always_ff @(posedge clk) begin
    if (step) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== rtl/avr_opcode_coverage_profiler_unit.sv =====
// ----------------------------------------------------------------------------
// avr_opcode_coverage_profiler_unit
// Opcode coverage profiler: classifies program words and keeps running totals.
// ----------------------------------------------------------------------------
// Usage:
//   Program words enter on the in_ channel in address order, one per transfer,
//   with in_word_present set when both bytes of the word were loaded. Every
//   input transfer yields exactly one result transfer on the out_ channel,
//   carrying the word's class and flags, the updated blocker count of its
//   class and all running totals.
//   The word is held in the input register, and the decode and all counter
//   updates form the single combinational stage between it and the result
//   register. Throughput is one word per cycle while out_ready keeps up,
//   set by the flop-based counters that update in that one stage.
//   A stalled receiver (out_ready low) holds the result; the input register
//   still takes one more word, after which in_ready drops until the result
//   is taken.
//   Reset clears all totals, the run length, the pending second-word skip and
//   the 28 per-class blocker counts at once; in_ready is high when it ends.
//   Counts saturate at the smaller of MAX_WORDS and 65535.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "avr_opcode_coverage_profiler_unit_macros.svh"

module avr_opcode_coverage_profiler_unit #(
  parameter int MAX_WORDS = ocp_pkg::MaxWordsDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [15:0]                       in_program_word,
  input  logic                              in_word_present,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ocp_pkg::ClassW-1:0]        out_word_class,
  output logic                              out_consumed,
  output logic                              out_simple_flag,
  output logic                              out_native_flag,
  output logic                              out_blocker_flag,
  output logic [ocp_pkg::CountW-1:0]        out_class_tally,
  output logic [ocp_pkg::CountW-1:0]        out_words_total,
  output logic [ocp_pkg::CountW-1:0]        out_simple_total,
  output logic [ocp_pkg::CountW-1:0]        out_native_total,
  output logic [ocp_pkg::CountW-1:0]        out_native_runs,
  output logic [ocp_pkg::CountW-1:0]        out_native_run_words,
  output logic [ocp_pkg::CountW-1:0]        out_longest_run
);

  logic          in_vld_r;
  logic [15:0]   word_r;
  logic          present_r;
  logic          out_vld_r;
  logic          step;
  logic          in_xfer;
  ocp_pkg::dec_t dec;
  ocp_pkg::res_t res;

  // The held word moves to the result register when that register is free.
  assign step     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready)            in_vld_r  <= in_valid;
      if (step)                out_vld_r <= 1'b1;
      else if (out_ready)      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      word_r    <= in_program_word;
      present_r <= in_word_present;
    end
  end

  ocp_decode u_decode (
    .word (word_r),
    .dec  (dec)
  );

  ocp_tally #(
    .MAX_WORDS (MAX_WORDS)
  ) u_tally (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .present (present_r),
    .dec     (dec),
    .res     (res)
  );

  assign out_valid            = out_vld_r;
  assign out_word_class       = res.word_class;
  assign out_consumed         = res.consumed;
  assign out_simple_flag      = res.simple_flag;
  assign out_native_flag      = res.native_flag;
  assign out_blocker_flag     = res.blocker_flag;
  assign out_class_tally      = res.class_tally;
  assign out_words_total      = res.words_total;
  assign out_simple_total     = res.simple_total;
  assign out_native_total     = res.native_total;
  assign out_native_runs      = res.native_runs;
  assign out_native_run_words = res.native_run_words;
  assign out_longest_run      = res.longest_run;

  // An unscanned word carries no class, flags or tally.
  `OCP_ASSERT_IMP(a_unscanned_clear, clk, rst_n, out_vld_r && !out_consumed,
    out_word_class == '0 && out_simple_flag == 1'b0 && out_native_flag == 1'b0 &&
    out_blocker_flag == 1'b0 && out_class_tally == '0)
  // A blocker is exactly a scanned word that is not native.
  `OCP_ASSERT_IMP(a_blocker_def, clk, rst_n, out_vld_r,
    out_blocker_flag == (out_consumed && !out_native_flag))
  // Every native word lies inside a run, so both totals advance together.
  `OCP_ASSERT_IMP(a_run_words, clk, rst_n, out_vld_r,
    out_native_run_words == out_native_total)
  // A result that is not taken stays for the next cycle.
  `OCP_ASSERT_NXT(a_result_hold, clk, rst_n, out_vld_r && !out_ready,
    out_vld_r && $stable(out_words_total))

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Opcode coverage profiler testbench
// Streams program words through the profiler under random stalls on both
// sides and checks every result against a cycle-free model of the
// classifier and its running totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // Opcode classes in the order the profiler reports them.
  typedef enum logic [ocp_pkg::ClassW-1:0] {
    OP_NOP, OP_MOVW, OP_CPC, OP_SBC, OP_ADD, OP_CPSE, OP_CP, OP_SUB, OP_ADC,
    OP_AND, OP_EOR, OP_OR, OP_MOV, OP_CPI, OP_SBCI, OP_SUBI, OP_ORI, OP_ANDI,
    OP_STS, OP_LDS, OP_LDST, OP_JMP, OP_CALL, OP_RJMP, OP_RCALL, OP_BRANCH,
    OP_SINGLE, OP_OTHER
  } opclass_t;

  typedef struct {
    logic [15:0] word;
    logic        present;
  } prog_word_t;

  localparam int          ItemTarget  = 850;
  localparam int          CycleLimit  = 300000;
  localparam int          HoldAfter   = 300;
  localparam int          HoldCycles  = 120;
  localparam logic [15:0] CountCap    = 16'((ocp_pkg::MaxWordsDefault < 65535) ?
                                            ocp_pkg::MaxWordsDefault : 65535);
  localparam int          NumShapes   = 27;
  localparam int          NumNative   = 6;

  // Opcode shapes for stimulus: fixed bits and the bits left free.
  localparam logic [15:0] ShapeBase [NumShapes] = '{
    16'h0000, 16'h0100, 16'h0400, 16'h0800, 16'h0c00, 16'h1000, 16'h1400,
    16'h1800, 16'h1c00, 16'h2000, 16'h3000, 16'h4000, 16'h5000, 16'h6000,
    16'h7000, 16'h9200, 16'h9000, 16'h8000, 16'ha000, 16'h940c, 16'h940e,
    16'hc000, 16'hd000, 16'hf000, 16'h9400, 16'he000, 16'hb000
  };
  localparam logic [15:0] ShapeFree [NumShapes] = '{
    16'h0000, 16'h00ff, 16'h03ff, 16'h03ff, 16'h03ff, 16'h03ff, 16'h03ff,
    16'h03ff, 16'h03ff, 16'h03ff, 16'h0fff, 16'h0fff, 16'h0fff, 16'h0fff,
    16'h0fff, 16'h01f0, 16'h01f0, 16'h0fff, 16'h0fff, 16'h01f0, 16'h01f1,
    16'h03ff, 16'h03ff, 16'h0fff, 16'h01f1, 16'h0fff, 16'h0fff
  };
  localparam logic [15:0] NativeBase [NumNative] = '{
    16'h0000, 16'h0100, 16'h2000, 16'h6000, 16'h7000, 16'he000
  };
  localparam logic [15:0] NativeFree [NumNative] = '{
    16'h0000, 16'h00ff, 16'h0fff, 16'h0fff, 16'h0fff, 16'h0fff
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [15:0]         in_program_word = '0;
  logic                in_word_present = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ocp_pkg::ClassW-1:0] out_word_class;
  logic                out_consumed;
  logic                out_simple_flag;
  logic                out_native_flag;
  logic                out_blocker_flag;
  logic [ocp_pkg::CountW-1:0] out_class_tally;
  logic [ocp_pkg::CountW-1:0] out_words_total;
  logic [ocp_pkg::CountW-1:0] out_simple_total;
  logic [ocp_pkg::CountW-1:0] out_native_total;
  logic [ocp_pkg::CountW-1:0] out_native_runs;
  logic [ocp_pkg::CountW-1:0] out_native_run_words;
  logic [ocp_pkg::CountW-1:0] out_longest_run;

  avr_opcode_coverage_profiler_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_program_word      (in_program_word),
    .in_word_present      (in_word_present),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_word_class       (out_word_class),
    .out_consumed         (out_consumed),
    .out_simple_flag      (out_simple_flag),
    .out_native_flag      (out_native_flag),
    .out_blocker_flag     (out_blocker_flag),
    .out_class_tally      (out_class_tally),
    .out_words_total      (out_words_total),
    .out_simple_total     (out_simple_total),
    .out_native_total     (out_native_total),
    .out_native_runs      (out_native_runs),
    .out_native_run_words (out_native_run_words),
    .out_longest_run      (out_longest_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Profiler model state.
  logic              skip_next;
  logic [15:0]       run_len;
  logic [15:0]       word_cnt;
  logic [15:0]       simple_cnt;
  logic [15:0]       native_cnt;
  logic [15:0]       run_cnt;
  logic [15:0]       run_word_cnt;
  logic [15:0]       longest;
  logic [15:0]       blocker_tally [ocp_pkg::NumClasses];

  prog_word_t        program_queue [$];
  ocp_pkg::res_t     expected_profile [$];
  int                words_sent = 0;
  int                error_count = 0;
  int                cycle_count = 0;
  int                send_gap = 0;
  int                stall_left = 0;
  int                hold_left = 0;
  bit                hold_done = 0;
  prog_word_t        next_word;
  ocp_pkg::res_t     predicted;
  ocp_pkg::res_t     wanted;

  function automatic opclass_t opcode_class(input logic [15:0] w);
    casez (w)
      16'b0000_0000_0000_0000: return OP_NOP;
      16'b0000_0001_????_????: return OP_MOVW;
      16'b0000_01??_????_????: return OP_CPC;
      16'b0000_10??_????_????: return OP_SBC;
      16'b0000_11??_????_????: return OP_ADD;
      16'b0001_00??_????_????: return OP_CPSE;
      16'b0001_01??_????_????: return OP_CP;
      16'b0001_10??_????_????: return OP_SUB;
      16'b0001_11??_????_????: return OP_ADC;
      16'b0010_00??_????_????: return OP_AND;
      16'b0010_01??_????_????: return OP_EOR;
      16'b0010_10??_????_????: return OP_OR;
      16'b0010_11??_????_????: return OP_MOV;
      16'b0011_????_????_????: return OP_CPI;
      16'b0100_????_????_????: return OP_SBCI;
      16'b0101_????_????_????: return OP_SUBI;
      16'b0110_????_????_????: return OP_ORI;
      16'b0111_????_????_????: return OP_ANDI;
      16'b1001_001?_????_0000: return OP_STS;
      16'b1001_000?_????_0000: return OP_LDS;
      16'b1000_????_????_????: return OP_LDST;
      16'b1010_????_????_????: return OP_LDST;
      16'b1001_010?_????_1100: return OP_JMP;
      16'b1001_010?_????_111?: return OP_CALL;
      16'b1100_00??_????_????: return OP_RJMP;
      16'b1101_00??_????_????: return OP_RCALL;
      16'b1111_????_????_????: return OP_BRANCH;
      16'b1001_010?_????_000?: return OP_SINGLE;
      default:                 return OP_OTHER;
    endcase
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v < CountCap) ? v + 16'd1 : CountCap;
  endfunction

  // Work out the profiler's result for one program word and advance the model.
  task automatic predict_profile(input logic [15:0] w, input logic present,
                                 output ocp_pkg::res_t r);
    opclass_t cls;
    logic     simple_w;
    logic     native_w;
    logic     two_word;
    r = '0;
    if (skip_next) begin
      skip_next = 1'b0;
    end else if (!present) begin
      run_len = '0;
    end else begin
      cls      = opcode_class(w);
      simple_w = (w == 16'h0000) || (w[15:8] == 8'h01) ||
                 (w[15:12] inside {4'h0, 4'h1} && w[11:10] != 2'b00) ||
                 (w[15:12] inside {4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'he});
      native_w = (w == 16'h0000) || (w[15:8] == 8'h01) ||
                 (w[15:12] inside {4'h2, 4'h6, 4'h7, 4'he});
      two_word = (w & 16'hfe0f) inside {16'h9200, 16'h9000, 16'h940c, 16'h940e};
      word_cnt = bump(word_cnt);
      if (simple_w) simple_cnt = bump(simple_cnt);
      if (native_w) begin
        native_cnt = bump(native_cnt);
        if (run_len == 16'd0) run_cnt = bump(run_cnt);
        run_len      = bump(run_len);
        run_word_cnt = bump(run_word_cnt);
        if (run_len > longest) longest = run_len;
      end else begin
        run_len = '0;
        blocker_tally[cls] = bump(blocker_tally[cls]);
        if (two_word) skip_next = 1'b1;
      end
      r.word_class   = cls;
      r.consumed     = 1'b1;
      r.simple_flag  = simple_w;
      r.native_flag  = native_w;
      r.blocker_flag = !native_w;
      r.class_tally  = blocker_tally[cls];
    end
    r.words_total      = word_cnt;
    r.simple_total     = simple_cnt;
    r.native_total     = native_cnt;
    r.native_runs      = run_cnt;
    r.native_run_words = run_word_cnt;
    r.longest_run      = longest;
  endtask

  // Mostly short gaps, a few long ones, and whole stretches with none.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_count % 700) < 160) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_word(input logic [15:0] w, input logic present);
    prog_word_t p;
    p.word    = w;
    p.present = present;
    program_queue.push_back(p);
  endtask

  task automatic check_field(input string tag, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sender: predicts each accepted word and offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_profile(in_program_word, in_word_present, predicted);
        expected_profile.push_back(predicted);
        words_sent <= words_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (program_queue.size() > 0) begin
          next_word = program_queue.pop_front();
          in_program_word <= next_word.word;
          in_word_present <= next_word.present;
          in_valid <= 1'b1;
          send_gap = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off so the profiler backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && words_sent >= HoldAfter) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= idle_len();
      out_ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_profile.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got class %0d words %0d",
                 $time, out_word_class, out_words_total);
        error_count++;
      end else begin
        wanted = expected_profile.pop_front();
        check_field("word_class", 16'(wanted.word_class), 16'(out_word_class));
        check_field("consumed", 16'(wanted.consumed), 16'(out_consumed));
        check_field("simple_flag", 16'(wanted.simple_flag), 16'(out_simple_flag));
        check_field("native_flag", 16'(wanted.native_flag), 16'(out_native_flag));
        check_field("blocker_flag", 16'(wanted.blocker_flag),
                    16'(out_blocker_flag));
        check_field("class_tally", wanted.class_tally, out_class_tally);
        check_field("words_total", wanted.words_total, out_words_total);
        check_field("simple_total", wanted.simple_total, out_simple_total);
        check_field("native_total", wanted.native_total, out_native_total);
        check_field("native_runs", wanted.native_runs, out_native_runs);
        check_field("native_run_words", wanted.native_run_words,
                    out_native_run_words);
        check_field("longest_run", wanted.longest_run, out_longest_run);
      end
    end
  end

  initial begin
    int         total_words;
    int         pick;
    int         k;
    logic [15:0] w;

    skip_next    = 1'b0;
    run_len      = '0;
    word_cnt     = '0;
    simple_cnt   = '0;
    native_cnt   = '0;
    run_cnt      = '0;
    run_word_cnt = '0;
    longest      = '0;
    for (int c = 0; c < ocp_pkg::NumClasses; c++) blocker_tally[c] = '0;

    // Directed words: field extremes, run breaks and the second-word skip.
    add_word(16'h0000, 1'b1);
    add_word(16'h01ff, 1'b1);
    add_word(16'h2c5a, 1'b1);
    add_word(16'hffff, 1'b1);
    add_word(16'h0000, 1'b0);
    add_word(16'he5a3, 1'b1);
    add_word(16'h6f0f, 1'b1);
    add_word(16'h0400, 1'b1);
    add_word(16'h9200, 1'b1);
    add_word(16'h1234, 1'b1);
    add_word(16'h91f0, 1'b1);
    add_word(16'hffff, 1'b0);
    add_word(16'h940c, 1'b1);
    add_word(16'h0000, 1'b1);
    add_word(16'h940e, 1'b1);
    add_word(16'he000, 1'b1);
    // A call form with the low bit set is not a two-word opcode.
    add_word(16'h940f, 1'b1);
    add_word(16'h0000, 1'b1);
    add_word(16'h9400, 1'b1);
    add_word(16'h8000, 1'b1);
    add_word(16'hc000, 1'b1);
    add_word(16'hd3ff, 1'b1);
    add_word(16'h00ff, 1'b1);
    add_word(16'h1000, 1'b1);
    add_word(16'h3000, 1'b1);

    while (program_queue.size() < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        add_word(16'($urandom()), 1'b0);
      end else if (pick < 28) begin
        add_word(16'($urandom()), 1'b1);
      end else if (pick < 45) begin
        // A run of native words, then a random word that may break it.
        repeat ($urandom_range(2, 10)) begin
          k = $urandom_range(0, NumNative - 1);
          add_word(NativeBase[k] | (16'($urandom()) & NativeFree[k]), 1'b1);
        end
        k = $urandom_range(0, NumShapes - 1);
        add_word(ShapeBase[k] | (16'($urandom()) & ShapeFree[k]),
                 1'($urandom_range(0, 3) != 0));
      end else if (pick < 57) begin
        k = 15 + $urandom_range(0, 1) + 4 * $urandom_range(0, 1);
        add_word(ShapeBase[k] | (16'($urandom()) & ShapeFree[k]), 1'b1);
        add_word(16'($urandom()), 1'($urandom_range(0, 4) != 0));
      end else begin
        k = $urandom_range(0, NumShapes - 1);
        w = ShapeBase[k] | (16'($urandom()) & ShapeFree[k]);
        add_word(w, 1'b1);
      end
    end
    total_words = program_queue.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    wait (words_sent == total_words);
    wait (expected_profile.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ocp_pkg.sv
rtl/ocp_decode.sv
rtl/ocp_tally.sv
rtl/avr_opcode_coverage_profiler_unit.sv
tb/sv/testbench.sv
